// ===== hw/rtl/sdf_pkg.sv =====
// Shared types and constants for the substring delete filter.
// Used by every module of the block; depends on nothing else.
package sdf_pkg;

    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 4;
    localparam int PAT_BYTES   = 8;
    localparam int PAT_BITS    = PAT_BYTES * CHAR_W;
    localparam int PAT_MAX_DEF = 8;
    localparam int ADDR_W      = 4;
    localparam int REG_SEL_BIT = 3;

    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_PATTERN_BYTES  = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]    pattern_length;
        logic [PAT_BITS-1:0] pattern_bytes;
    } sdf_cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              out_last;
        logic              status;
    } sdf_beat_t;

endpackage

// ===== hw/rtl/sdf_cfg.sv =====
// APB register file holding the pattern length and the pattern bytes.
// Depends on sdf_pkg.
module sdf_cfg import sdf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PAT_BITS-1:0] pwdata,
    output logic [PAT_BITS-1:0] prdata,
    output logic                pready,
    output sdf_cfg_t            cfg
);

    logic [LEN_W-1:0]    len_reg;
    logic [PAT_BITS-1:0] pat_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            pat_reg <= '0;
        end else if (wr_en) begin
            if (paddr[REG_SEL_BIT] == REG_PATTERN_LENGTH) begin
                len_reg <= pwdata[LEN_W-1:0];
            end else begin
                pat_reg <= pwdata;
            end
        end
    end

    always_comb begin
        if (paddr[REG_SEL_BIT] == REG_PATTERN_BYTES) begin
            prdata = pat_reg;
        end else begin
            prdata = {{(PAT_BITS-LEN_W){1'b0}}, len_reg};
        end
    end

    assign cfg.pattern_length = len_reg;
    assign cfg.pattern_bytes  = pat_reg;

endmodule

// ===== hw/rtl/sdf_core.sv =====
// Match window: appends a character, compares the window with the pattern
// and emits or drops bytes, one window step per cycle while slot_free. Depends on sdf_pkg.
module sdf_core import sdf_pkg::*; #(
    parameter int PAT_MAX = PAT_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_last,
    input  logic              in_valid,
    output logic              in_ready,
    input  sdf_cfg_t          cfg,
    input  logic              slot_free,
    output logic              res_load,
    output sdf_beat_t         res_beat
);

    localparam int FW = $clog2(PAT_MAX + 1);
    localparam int SW = $clog2(PAT_MAX + 2);
    localparam int CW = (SW > LEN_W) ? SW : LEN_W;

    logic [CHAR_W-1:0] win_reg [PAT_MAX];
    logic [CHAR_W-1:0] win_next [PAT_MAX];
    logic [FW-1:0]     fill_reg, fill_next;
    logic [SW-1:0]     seen_reg, seen_next;
    logic              lastp_reg, lastp_next;
    logic              err_reg, err_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [CHAR_W-1:0] hold_char_reg, hold_char_next;

    logic [CHAR_W-1:0] pb [PAT_MAX];
    logic [CHAR_W-1:0] ws [PAT_MAX];
    logic [CHAR_W-1:0] nw [PAT_MAX];
    logic [FW-1:0]     fs, fn;
    logic [SW-1:0]     seen_inc;
    logic [CW-1:0]     len_c;
    logic              ls, pass, busy, active, finalize;
    logic              in_loop, do_op, match, drop_pat, emit;

    genvar gk;
    for (gk = 0; gk < PAT_MAX; gk++) begin : g_pat
        if (gk < PAT_BYTES) begin : g_reg
            assign pb[gk] = cfg.pattern_bytes[CHAR_W*gk +: CHAR_W];
        end else begin : g_zero
            assign pb[gk] = '0;
        end
    end

    assign len_c    = CW'(cfg.pattern_length);
    assign pass     = (len_c == '0) || (len_c > CW'(PAT_MAX));
    assign busy     = lastp_reg || (pass ? (fill_reg != '0) : (CW'(fill_reg) >= len_c));
    assign in_ready = slot_free && !busy;
    assign active   = slot_free && (busy || in_valid);
    assign finalize = lastp_reg && (fill_reg == '0);
    assign seen_inc = (seen_reg == SW'(PAT_MAX + 1)) ? seen_reg : seen_reg + SW'(1);

    always_comb begin
        ws = win_reg;
        fs = fill_reg;
        ls = lastp_reg;
        if (!busy) begin
            for (int i = 0; i < PAT_MAX; i++) begin
                if (FW'(i) == fill_reg) begin
                    ws[i] = in_char;
                end
            end
            fs = fill_reg + FW'(1);
            ls = in_last;
        end

        match = 1'b1;
        for (int k = 0; k < PAT_MAX; k++) begin
            if ((CW'(k) < len_c) && (ws[k] != pb[k])) begin
                match = 1'b0;
            end
        end

        in_loop  = !pass && (CW'(fs) >= len_c);
        do_op    = in_loop || ((pass || ls) && (fs != '0));
        drop_pat = in_loop && match;
        emit     = do_op && !drop_pat;

        for (int i = 0; i < PAT_MAX; i++) begin
            nw[i] = ws[i];
            if (emit) begin
                nw[i] = '0;
                if (i + 1 < PAT_MAX) begin
                    nw[i] = ws[i+1];
                end
            end else if (drop_pat) begin
                nw[i] = '0;
                for (int d = 1; d < PAT_MAX; d++) begin
                    if ((len_c == CW'(d)) && (i + d < PAT_MAX)) begin
                        nw[i] = ws[i+d];
                    end
                end
            end
        end

        if (emit) begin
            fn = fs - FW'(1);
        end else if (drop_pat) begin
            fn = fs - FW'(cfg.pattern_length);
        end else begin
            fn = fs;
        end
    end

    always_comb begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        seen_next       = seen_reg;
        lastp_next      = lastp_reg;
        err_next        = err_reg;
        hold_valid_next = hold_valid_reg;
        hold_char_next  = hold_char_reg;
        res_load        = 1'b0;
        res_beat        = '0;
        if (active) begin
            if (finalize) begin
                res_load            = 1'b1;
                res_beat.out_char   = hold_valid_reg ? hold_char_reg : '0;
                res_beat.char_valid = hold_valid_reg;
                res_beat.out_last   = 1'b1;
                res_beat.status     = err_reg;
                lastp_next          = 1'b0;
                hold_valid_next     = 1'b0;
            end else begin
                win_next   = nw;
                fill_next  = fn;
                lastp_next = ls;
                if (!busy) begin
                    seen_next = in_last ? '0 : seen_inc;
                    if (in_last) begin
                        err_next = pass || (CW'(seen_inc) < len_c);
                    end
                end
                if (emit) begin
                    if (ls) begin
                        hold_char_next  = ws[0];
                        hold_valid_next = 1'b1;
                        if (hold_valid_reg) begin
                            res_load            = 1'b1;
                            res_beat.out_char   = hold_char_reg;
                            res_beat.char_valid = 1'b1;
                        end
                    end else begin
                        res_load            = 1'b1;
                        res_beat.out_char   = ws[0];
                        res_beat.char_valid = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PAT_MAX; i++) begin
                win_reg[i] <= '0;
            end
            fill_reg       <= '0;
            seen_reg       <= '0;
            lastp_reg      <= 1'b0;
            err_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            win_reg        <= win_next;
            fill_reg       <= fill_next;
            seen_reg       <= seen_next;
            lastp_reg      <= lastp_next;
            err_reg        <= err_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_char_reg <= hold_char_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(PAT_MAX))
        else $error("window fill above its depth");

    a_hold_in_last: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> lastp_reg)
        else $error("held character outside the end of a string");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && res_beat.out_last |=> !lastp_reg && !hold_valid_reg && fill_reg == '0)
        else $error("state not cleared after the end beat");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        lastp_reg && fill_reg != '0 |-> !in_ready)
        else $error("input taken while a string end is flushing");

endmodule

// ===== hw/rtl/sdf_out.sv =====
// Result register of the filter: holds one beat until the sink takes it.
// Depends on sdf_pkg.
module sdf_out import sdf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_load,
    input  sdf_beat_t         res_beat,
    output logic              slot_free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [CHAR_W-1:0] m_axis_tdata,
    output logic              m_axis_tlast,
    output logic [1:0]        m_axis_tuser
);

    logic      valid_reg, valid_next;
    sdf_beat_t beat_reg;

    assign slot_free  = !valid_reg || m_axis_tready;
    assign valid_next = res_load || (valid_reg && !m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            beat_reg <= res_beat;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = beat_reg.out_char;
    assign m_axis_tlast  = beat_reg.out_last;
    assign m_axis_tuser  = {beat_reg.status, beat_reg.char_valid};

endmodule

// ===== hw/rtl/substring_delete_filter.sv =====
// Channel   Dir  Beat contents
// s_axis    in   tdata = in_char, tlast = in_last
// m_axis    out  tdata = out_char, tuser = {status, char_valid}, tlast = out_last
// apb       in   0x0 pattern_length, 0x8 pattern_bytes
//
// One character is taken per cycle while the string runs; the window step
// that compares it with the pattern sits between the window register and
// the result register. A string's last character keeps the input stalled
// while the window drains and until the end beat is loaded.
// Synchronous active-low reset clears the window; a stalled sink holds the
// result register and the input waits.
module substring_delete_filter import sdf_pkg::*; #(
    parameter int PAT_MAX = PAT_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [CHAR_W-1:0]   s_axis_tdata,   // [7:0] in_char
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [CHAR_W-1:0]   m_axis_tdata,   // [7:0] out_char
    output logic                m_axis_tlast,
    output logic [1:0]          m_axis_tuser,   // [0] char_valid, [1] status
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PAT_BITS-1:0] pwdata,
    output logic [PAT_BITS-1:0] prdata,
    output logic                pready
);

    sdf_cfg_t  cfg;
    sdf_beat_t res_beat;
    logic      res_load;
    logic      slot_free;

    sdf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdf_core #(
        .PAT_MAX (PAT_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_char   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cfg       (cfg),
        .slot_free (slot_free),
        .res_load  (res_load),
        .res_beat  (res_beat)
    );

    sdf_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_load      (res_load),
        .res_beat      (res_beat),
        .slot_free     (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for substring_delete_filter: it programs patterns over APB,
// streams strings in, and checks every result beat against a built-in predictor.
// Needs only the filter RTL and sdf_pkg.
module testbench;
    import sdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAT_MAX = PAT_MAX_DEF;
    localparam int SETTLE_CYCLES = 2 * PAT_MAX + 4;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_CHARS = 80;
    localparam logic [ADDR_W-1:0] ADDR_LENGTH = ADDR_W'(REG_PATTERN_LENGTH) << REG_SEL_BIT;
    localparam logic [ADDR_W-1:0] ADDR_BYTES = ADDR_W'(REG_PATTERN_BYTES) << REG_SEL_BIT;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_item_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [CHAR_W-1:0]   s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]   m_axis_tdata;
    logic                m_axis_tlast;
    logic [1:0]          m_axis_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [PAT_BITS-1:0] pwdata = '0;
    logic [PAT_BITS-1:0] prdata;
    logic                pready;

    char_item_t char_queue[$];
    char_item_t next_item;
    sdf_beat_t  expected_beats[$];
    sdf_beat_t  step_beats[$];
    sdf_beat_t  want;
    sdf_beat_t  got;

    logic [CHAR_W-1:0]   win [PAT_MAX];
    int unsigned         win_fill = 0;
    int unsigned         seen_cnt = 0;
    logic [LEN_W-1:0]    cfg_len = '0;
    logic [PAT_BITS-1:0] cfg_pat = '0;

    bit steady = 1'b0;
    int send_wait = 0;
    int stall_left = 0;
    int fail_count = 0;
    int chars_sent = 0;
    int quiet_cycles = 0;

    substring_delete_filter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int draw_wait();
        if (steady) begin
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic drop_front(input int unsigned cnt);
        if (cnt > win_fill) begin
            cnt = win_fill;
        end
        for (int i = 0; i < int'(win_fill - cnt); i++) begin
            win[i] = win[i + cnt];
        end
        win_fill -= cnt;
    endtask

    task automatic take_oldest();
        sdf_beat_t beat;
        if (win_fill == 0) begin
            return;
        end
        if (step_beats.size() < PAT_MAX) begin
            beat = '0;
            beat.out_char = win[0];
            beat.char_valid = 1'b1;
            step_beats.push_back(beat);
        end
        drop_front(1);
    endtask

    task automatic filter_char(input logic [CHAR_W-1:0] ch, input logic last);
        bit pass;
        bit hit;
        sdf_beat_t marker;
        step_beats.delete();
        pass = (cfg_len == 0) || (cfg_len > PAT_MAX);
        if (seen_cnt < PAT_MAX + 1) begin
            seen_cnt++;
        end
        if (win_fill >= PAT_MAX) begin
            take_oldest();
        end
        win[win_fill] = ch;
        win_fill++;
        if (pass) begin
            while (win_fill > 0) take_oldest();
        end else begin
            while (win_fill >= cfg_len) begin
                hit = 1'b1;
                for (int k = 0; k < int'(cfg_len); k++) begin
                    if (win[k] !== cfg_pat[8*k +: 8]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    drop_front(cfg_len);
                end else begin
                    take_oldest();
                end
            end
        end
        if (last) begin
            while (win_fill > 0) take_oldest();
            if (step_beats.size() == 0) begin
                marker = '0;
            end else begin
                marker = step_beats.pop_back();
            end
            marker.out_last = 1'b1;
            marker.status = pass || (seen_cnt < cfg_len);
            step_beats.push_back(marker);
            win_fill = 0;
            seen_cnt = 0;
        end
        foreach (step_beats[i]) begin
            expected_beats.push_back(step_beats[i]);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                filter_char(s_axis_tdata, s_axis_tlast);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (char_queue.size() > 0) begin
                    next_item = char_queue.pop_front();
                    s_axis_tdata <= next_item.ch;
                    s_axis_tlast <= next_item.last;
                    s_axis_tvalid <= 1'b1;
                    send_wait = draw_wait();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_char = m_axis_tdata;
                got.char_valid = m_axis_tuser[0];
                got.status = m_axis_tuser[1];
                got.out_last = m_axis_tlast;
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (got.out_char !== want.out_char) begin
                        $display("%0t: out_char expected %h, got %h",
                                 $time, want.out_char, got.out_char);
                        fail_count++;
                    end
                    if (got.char_valid !== want.char_valid) begin
                        $display("%0t: char_valid expected %b, got %b",
                                 $time, want.char_valid, got.char_valid);
                        fail_count++;
                    end
                    if (got.out_last !== want.out_last) begin
                        $display("%0t: out_last expected %b, got %b",
                                 $time, want.out_last, got.out_last);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %b, got %b",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                end
                stall_left = draw_wait();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || psel || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [PAT_BITS-1:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_pattern(input logic [LEN_W-1:0] len, input logic [PAT_BITS-1:0] pat);
        write_reg(ADDR_LENGTH, PAT_BITS'(len));
        write_reg(ADDR_BYTES, pat);
        cfg_len = len;
        cfg_pat = pat;
        @(negedge aclk);
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
        char_item_t item;
        item.ch = ch;
        item.last = last;
        char_queue.push_back(item);
        chars_sent++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (char_queue.size() != 0 || s_axis_tvalid || expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic add_random_string();
        logic [CHAR_W-1:0] text[$];
        int target;
        target = $urandom_range(1, 14);
        while (text.size() < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    if (cfg_len >= 1 && cfg_len <= PAT_MAX) begin
                        for (int k = 0; k < int'(cfg_len); k++) text.push_back(cfg_pat[8*k +: 8]);
                    end else begin
                        text.push_back(CHAR_W'($urandom));
                    end
                end
                4, 5, 6: text.push_back(cfg_pat[8*$urandom_range(0, PAT_BYTES-1) +: 8]);
                default: text.push_back(CHAR_W'($urandom));
            endcase
        end
        foreach (text[i]) push_char(text[i], i == text.size() - 1);
    endtask

    initial begin
        logic [LEN_W-1:0] len;
        logic [PAT_BITS-1:0] pat;
        logic [CHAR_W-1:0] sym_a;
        logic [CHAR_W-1:0] sym_b;
        int random_goal;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty pattern straight out of reset: passthrough with error status.
        push_char(8'h01, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h00, 1'b1);
        wait_idle();

        set_pattern(4'd1, 64'hFFFF_FFFF_FFFF_FF41);
        push_char(8'h41, 1'b0);
        push_char(8'h42, 1'b0);
        push_char(8'h41, 1'b1);
        push_char(8'h41, 1'b1);
        wait_idle();

        // Full-width pattern: an exact copy vanishes, a shorter string passes.
        steady = 1'b1;
        pat = 64'h00FF_5AA5_0180_7FFE;
        set_pattern(4'd8, pat);
        for (int k = 0; k < PAT_BYTES; k++) push_char(pat[8*k +: 8], k == PAT_BYTES - 1);
        push_char(pat[7:0], 1'b0);
        push_char(pat[15:8], 1'b0);
        push_char(8'h33, 1'b1);
        wait_idle();
        steady = 1'b0;

        set_pattern(4'd15, 64'h0);
        push_char(8'h7E, 1'b0);
        push_char(8'h81, 1'b1);
        wait_idle();

        // The pattern changes while part of a string sits in the window.
        set_pattern(4'd3, 64'h0000_0000_0063_6261);
        push_char(8'h78, 1'b0);
        push_char(8'h61, 1'b0);
        push_char(8'h62, 1'b0);
        wait_idle();
        set_pattern(4'd2, 64'h0000_0000_0000_6261);
        push_char(8'h63, 1'b0);
        push_char(8'h64, 1'b1);
        wait_idle();

        random_goal = chars_sent + RANDOM_CHARS;
        while (chars_sent < random_goal) begin
            case ($urandom_range(0, 11))
                0: len = 4'd0;
                1: len = LEN_W'($urandom_range(PAT_MAX + 1, 15));
                2: len = 4'd1;
                3: len = LEN_W'(PAT_MAX);
                default: len = LEN_W'($urandom_range(1, PAT_MAX));
            endcase
            pat = {$urandom, $urandom};
            if ($urandom_range(0, 2) == 0) begin
                sym_a = CHAR_W'($urandom);
                sym_b = CHAR_W'($urandom);
                for (int k = 0; k < PAT_BYTES; k++) begin
                    pat[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
                end
            end
            steady = ($urandom_range(0, 3) == 0);
            set_pattern(len, pat);
            repeat ($urandom_range(1, 3)) add_random_string();
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
